>>> design/mstt_pkg.sv
`default_nettype none
package mstt_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int TICK_W        = 32;
    localparam int SLOT_W        = 4;
    localparam int KIND_W        = 3;
    localparam int REQ_W         = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK     = 2'd0,
        REQ_ONESHOT  = 2'd1,
        REQ_PERIODIC = 2'd2,
        REQ_CLEAR    = 2'd3
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_GRANT  = 3'd0,
        KIND_REJECT = 3'd1,
        KIND_FIRE   = 3'd2,
        KIND_IDLE   = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [SLOT_W-1:0]  slot;
        logic [TICK_W-1:0]  uptime;
        logic               last;
    } res_t;

endpackage
`default_nettype wire

>>> design/mstt_ram.sv
`default_nettype none
module mstt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> design/mstt_out.sv
`default_nettype none
module mstt_out (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire mstt_pkg::res_t                 push_res,
    output logic                                free,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [mstt_pkg::KIND_W-1:0]         result_kind,
    output logic [mstt_pkg::SLOT_W-1:0]         result_slot,
    output logic [mstt_pkg::TICK_W-1:0]         uptime,
    output logic                                last
);

    logic           valid_reg;
    mstt_pkg::res_t res_reg;

    assign free        = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign result_kind = res_reg.kind;
    assign result_slot = res_reg.slot;
    assign uptime      = res_reg.uptime;
    assign last        = res_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

endmodule
`default_nettype wire

>>> design/mstt_seq.sv
`default_nettype none
module mstt_seq #(
    parameter int NUM_SLOTS = mstt_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [mstt_pkg::REQ_W-1:0]   req_type,
    input  wire logic [mstt_pkg::TICK_W-1:0]  period,
    input  wire logic [mstt_pkg::SLOT_W-1:0]  slot_id,
    input  wire logic                         out_free,
    output logic                              push,
    output mstt_pkg::res_t                    push_res
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int SW = (IW > mstt_pkg::SLOT_W) ? IW : mstt_pkg::SLOT_W;
    localparam int TW = mstt_pkg::TICK_W;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FLUSH, S_FIND, S_PUSH} state_t;

    function automatic logic [mstt_pkg::SLOT_W-1:0] to_slot(input logic [IW-1:0] idx);
        logic [SW-1:0] ext;
        ext = SW'(idx);
        return ext[mstt_pkg::SLOT_W-1:0];
    endfunction

    state_t                        state_reg, state_next;
    logic [TW-1:0]                 tick_reg, tick_next;
    logic [NUM_SLOTS-1:0]          active_reg, active_next;
    logic [NUM_SLOTS-1:0]          periodic_reg, periodic_next;
    logic [IW:0]                   rd_idx_reg, rd_idx_next;
    logic                          pv_reg, pv_next;
    logic [IW-1:0]                 p_idx_reg, p_idx_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [IW-1:0]                 pend_slot_reg, pend_slot_next;
    logic [IW-1:0]                 f_idx_reg, f_idx_next;
    logic [TW-1:0]                 period_reg, period_next;
    logic                          mode_reg, mode_next;
    mstt_pkg::kind_t               hold_kind_reg, hold_kind_next;
    logic [mstt_pkg::SLOT_W-1:0]   hold_slot_reg, hold_slot_next;

    logic                          ram_re;
    logic [IW-1:0]                 ram_raddr;
    logic                          rem_we;
    logic [IW-1:0]                 rem_waddr;
    logic [TW-1:0]                 rem_wdata;
    logic                          rel_we;
    logic [TW-1:0]                 rem_rdata;
    logic [TW-1:0]                 rel_rdata;

    logic                          p_active;
    logic                          fire;
    logic                          stall;
    logic                          rd_more;

    mstt_ram #(.WIDTH(TW), .DEPTH(NUM_SLOTS)) u_rem_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rem_rdata)
    );

    mstt_ram #(.WIDTH(TW), .DEPTH(NUM_SLOTS)) u_rel_ram (
        .clk   (clk),
        .we    (rel_we),
        .waddr (f_idx_reg),
        .wdata (period_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rel_rdata)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign p_active = active_reg[p_idx_reg];
    assign fire     = pv_reg && p_active && (rem_rdata == TW'(1));
    assign stall    = fire && pend_valid_reg && !out_free;
    assign rd_more  = rd_idx_reg < (IW+1)'(NUM_SLOTS);

    always_comb
    begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        active_next     = active_reg;
        periodic_next   = periodic_reg;
        rd_idx_next     = rd_idx_reg;
        pv_next         = pv_reg;
        p_idx_next      = p_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        f_idx_next      = f_idx_reg;
        period_next     = period_reg;
        mode_next       = mode_reg;
        hold_kind_next  = hold_kind_reg;
        hold_slot_next  = hold_slot_reg;

        push            = 1'b0;
        push_res.kind   = mstt_pkg::KIND_IDLE;
        push_res.slot   = '0;
        push_res.uptime = tick_reg;
        push_res.last   = 1'b0;

        ram_re          = 1'b0;
        ram_raddr       = rd_idx_reg[IW-1:0];
        rem_we          = 1'b0;
        rem_waddr       = p_idx_reg;
        rem_wdata       = rem_rdata - TW'(1);
        rel_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (mstt_pkg::req_t'(req_type))
                        mstt_pkg::REQ_TICK:
                        begin
                            tick_next       = tick_reg + TW'(1);
                            rd_idx_next     = '0;
                            pv_next         = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        mstt_pkg::REQ_ONESHOT, mstt_pkg::REQ_PERIODIC:
                        begin
                            period_next = period;
                            mode_next   = (req_type == mstt_pkg::REQ_PERIODIC);
                            f_idx_next  = '0;
                            if (period == '0)
                            begin
                                hold_kind_next = mstt_pkg::KIND_REJECT;
                                hold_slot_next = '0;
                                state_next     = S_PUSH;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        mstt_pkg::REQ_CLEAR:
                        begin
                            hold_slot_next = slot_id;
                            if (32'(slot_id) < 32'(NUM_SLOTS))
                            begin
                                for (int i = 0; i < NUM_SLOTS; i++)
                                begin
                                    if (32'(i) == 32'(slot_id))
                                    begin
                                        active_next[i]   = 1'b0;
                                        periodic_next[i] = 1'b0;
                                    end
                                end
                                hold_kind_next = mstt_pkg::KIND_CLEAR;
                            end
                            else
                            begin
                                hold_kind_next = mstt_pkg::KIND_REJECT;
                            end
                            state_next = S_PUSH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!stall)
                begin
                    ram_re     = rd_more;
                    pv_next    = rd_more;
                    p_idx_next = rd_idx_reg[IW-1:0];
                    if (rd_more)
                    begin
                        rd_idx_next = rd_idx_reg + (IW+1)'(1);
                    end
                    if (pv_reg && p_active)
                    begin
                        rem_we = 1'b1;
                        if (fire)
                        begin
                            if (periodic_reg[p_idx_reg])
                            begin
                                rem_wdata = rel_rdata;
                            end
                            else
                            begin
                                active_next[p_idx_reg] = 1'b0;
                            end
                            if (pend_valid_reg)
                            begin
                                push          = 1'b1;
                                push_res.kind = mstt_pkg::KIND_FIRE;
                                push_res.slot = to_slot(pend_slot_reg);
                            end
                            pend_valid_next = 1'b1;
                            pend_slot_next  = p_idx_reg;
                        end
                    end
                    if (!pv_reg && !rd_more)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    push          = 1'b1;
                    push_res.last = 1'b1;
                    if (pend_valid_reg)
                    begin
                        push_res.kind = mstt_pkg::KIND_FIRE;
                        push_res.slot = to_slot(pend_slot_reg);
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_FIND:
            begin
                if (!active_reg[f_idx_reg])
                begin
                    rem_we                   = 1'b1;
                    rem_waddr                = f_idx_reg;
                    rem_wdata                = period_reg;
                    rel_we                   = 1'b1;
                    active_next[f_idx_reg]   = 1'b1;
                    periodic_next[f_idx_reg] = mode_reg;
                    hold_kind_next           = mstt_pkg::KIND_GRANT;
                    hold_slot_next           = to_slot(f_idx_reg);
                    state_next               = S_PUSH;
                end
                else if (f_idx_reg == IW'(NUM_SLOTS - 1))
                begin
                    hold_kind_next = mstt_pkg::KIND_REJECT;
                    hold_slot_next = '0;
                    state_next     = S_PUSH;
                end
                else
                begin
                    f_idx_next = f_idx_reg + IW'(1);
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    push          = 1'b1;
                    push_res.kind = hold_kind_reg;
                    push_res.slot = hold_slot_reg;
                    push_res.last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            active_reg     <= '0;
            periodic_reg   <= '0;
            rd_idx_reg     <= '0;
            pv_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            f_idx_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            active_reg     <= active_next;
            periodic_reg   <= periodic_next;
            rd_idx_reg     <= rd_idx_next;
            pv_reg         <= pv_next;
            pend_valid_reg <= pend_valid_next;
            f_idx_reg      <= f_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg     <= p_idx_next;
        pend_slot_reg <= pend_slot_next;
        period_reg    <= period_next;
        mode_reg      <= mode_next;
        hold_kind_reg <= hold_kind_next;
        hold_slot_reg <= hold_slot_next;
    end

endmodule
`default_nettype wire

>>> design/multi_slot_tick_timer_table_top.sv
// channel | handshake            | words
// --------+----------------------+------------------------------------------
// in      | in_valid / in_ready  | req_type, period, slot_id
// out     | out_valid / out_ready| result_kind, result_slot, uptime, last
//
// a tick walks the slots through the countdown memory, one slot per cycle
// unless the output stalls it; a set scans for the lowest free slot; a
// clear or a zero-period set goes straight to its result word
// reset clears the active bits and the uptime at once, no clearing pass
// a full output register holds the slot walk until the pending word is taken
`default_nettype none
module multi_slot_tick_timer_table_top #(
    parameter int NUM_SLOTS = mstt_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [mstt_pkg::REQ_W-1:0]   req_type,
    input  wire logic [mstt_pkg::TICK_W-1:0]  period,
    input  wire logic [mstt_pkg::SLOT_W-1:0]  slot_id,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [mstt_pkg::KIND_W-1:0]       result_kind,
    output logic [mstt_pkg::SLOT_W-1:0]       result_slot,
    output logic [mstt_pkg::TICK_W-1:0]       uptime,
    output logic                              last
);

    logic           push;
    logic           out_free;
    mstt_pkg::res_t push_res;

    mstt_seq #(.NUM_SLOTS(NUM_SLOTS)) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .period   (period),
        .slot_id  (slot_id),
        .out_free (out_free),
        .push     (push),
        .push_res (push_res)
    );

    mstt_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_res    (push_res),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .result_slot (result_slot),
        .uptime      (uptime),
        .last        (last)
    );

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = mstt_pkg::NUM_SLOTS_DEF;
    localparam int QUIET_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 50;
    localparam int WORDS_PER_PASS = 134;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          out_ready = 1'b0;
    logic [mstt_pkg::REQ_W-1:0]    req_type  = '0;
    logic [mstt_pkg::TICK_W-1:0]   period    = '0;
    logic [mstt_pkg::SLOT_W-1:0]   slot_id   = '0;
    logic                          in_ready;
    logic                          out_valid;
    logic [mstt_pkg::KIND_W-1:0]   result_kind;
    logic [mstt_pkg::SLOT_W-1:0]   result_slot;
    logic [mstt_pkg::TICK_W-1:0]   uptime;
    logic                          last;

    // fixed expectation riding along with the word on offer
    bit                            word_typed = 1'b0;
    mstt_pkg::res_t                word_exp   = '0;

    int                            gap_pct    = 0;
    int                            stall_pct  = 0;
    int                            hold_left  = 0;
    int                            quiet      = 0;
    int                            mismatches = 0;

    bit                            slot_on     [SLOTS];
    bit                            slot_repeat [SLOTS];
    logic [mstt_pkg::TICK_W-1:0]   slot_left   [SLOTS];
    logic [mstt_pkg::TICK_W-1:0]   slot_reload [SLOTS];
    logic [mstt_pkg::TICK_W-1:0]   tick_total = '0;
    mstt_pkg::res_t                expected_results[$];

    typedef struct {
        mstt_pkg::req_t               req;
        logic [mstt_pkg::TICK_W-1:0]  per;
        logic [mstt_pkg::SLOT_W-1:0]  sid;
        int                           reps;
        bit                           typed;
        mstt_pkg::kind_t              kind;
        logic [mstt_pkg::SLOT_W-1:0]  slot;
        logic [mstt_pkg::TICK_W-1:0]  up;
    } stim_row_t;

    stim_row_t directed_rows [15] = '{
        '{mstt_pkg::REQ_TICK, 32'd0, 4'd0, 1, 1'b1, mstt_pkg::KIND_IDLE, 4'd0, 32'd1},
        '{mstt_pkg::REQ_ONESHOT, 32'd0, 4'd0, 1, 1'b1, mstt_pkg::KIND_REJECT, 4'd0, 32'd1},
        '{mstt_pkg::REQ_PERIODIC, 32'd0, 4'd9, 1, 1'b1, mstt_pkg::KIND_REJECT, 4'd0, 32'd1},
        '{mstt_pkg::REQ_CLEAR, 32'd0, 4'd15, 1, 1'b1, mstt_pkg::KIND_CLEAR, 4'd15, 32'd1},
        '{mstt_pkg::REQ_ONESHOT, 32'd1, 4'd0, 1, 1'b1, mstt_pkg::KIND_GRANT, 4'd0, 32'd1},
        '{mstt_pkg::REQ_PERIODIC, 32'd1, 4'd0, 15, 1'b0, mstt_pkg::KIND_GRANT, 4'd0, 32'd0},
        '{mstt_pkg::REQ_ONESHOT, 32'd5, 4'd0, 1, 1'b1, mstt_pkg::KIND_REJECT, 4'd0, 32'd1},
        '{mstt_pkg::REQ_PERIODIC, 32'hFFFF_FFFF, 4'd0, 1, 1'b1, mstt_pkg::KIND_REJECT, 4'd0,
          32'd1},
        '{mstt_pkg::REQ_TICK, 32'd0, 4'd0, 1, 1'b0, mstt_pkg::KIND_GRANT, 4'd0, 32'd0},
        '{mstt_pkg::REQ_ONESHOT, 32'hFFFF_FFFF, 4'd0, 1, 1'b1, mstt_pkg::KIND_GRANT, 4'd0,
          32'd2},
        '{mstt_pkg::REQ_CLEAR, 32'd0, 4'd3, 1, 1'b1, mstt_pkg::KIND_CLEAR, 4'd3, 32'd2},
        '{mstt_pkg::REQ_PERIODIC, 32'd2, 4'd0, 1, 1'b1, mstt_pkg::KIND_GRANT, 4'd3, 32'd2},
        '{mstt_pkg::REQ_TICK, 32'd0, 4'd0, 1, 1'b0, mstt_pkg::KIND_GRANT, 4'd0, 32'd0},
        '{mstt_pkg::REQ_TICK, 32'd0, 4'd0, 1, 1'b0, mstt_pkg::KIND_GRANT, 4'd0, 32'd0},
        '{mstt_pkg::REQ_CLEAR, 32'd0, 4'd0, 1, 1'b1, mstt_pkg::KIND_CLEAR, 4'd0, 32'd4}
    };

    multi_slot_tick_timer_table_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .period      (period),
        .slot_id     (slot_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .result_slot (result_slot),
        .uptime      (uptime),
        .last        (last)
    );

    always #2 clk = ~clk;

    function automatic void add_result(mstt_pkg::kind_t kind, int slot);
        mstt_pkg::res_t r;
        r.kind   = kind;
        r.slot   = slot[mstt_pkg::SLOT_W-1:0];
        r.uptime = tick_total;
        r.last   = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_timers(logic [mstt_pkg::REQ_W-1:0] req,
                                           logic [mstt_pkg::TICK_W-1:0] per,
                                           logic [mstt_pkg::SLOT_W-1:0] sid);
        int fired;
        int found;
        fired = 0;
        found = -1;
        case (mstt_pkg::req_t'(req))
            mstt_pkg::REQ_TICK:
            begin
                tick_total = tick_total + 1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_on[i])
                    begin
                        slot_left[i] = slot_left[i] - 1;
                        if (slot_left[i] == '0)
                        begin
                            add_result(mstt_pkg::KIND_FIRE, i);
                            fired++;
                            if (slot_repeat[i])
                                slot_left[i] = slot_reload[i];
                            else
                                slot_on[i] = 1'b0;
                        end
                    end
                end
                if (fired == 0)
                    add_result(mstt_pkg::KIND_IDLE, 0);
            end
            mstt_pkg::REQ_ONESHOT, mstt_pkg::REQ_PERIODIC:
            begin
                if (per != '0)
                begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!slot_on[i])
                            found = i;
                end
                if (found < 0)
                    add_result(mstt_pkg::KIND_REJECT, 0);
                else
                begin
                    slot_on[found]     = 1'b1;
                    slot_left[found]   = per;
                    slot_repeat[found] = (mstt_pkg::req_t'(req) == mstt_pkg::REQ_PERIODIC);
                    if (mstt_pkg::req_t'(req) == mstt_pkg::REQ_PERIODIC)
                        slot_reload[found] = per;
                    add_result(mstt_pkg::KIND_GRANT, found);
                end
            end
            default:
            begin
                if (int'(sid) < SLOTS)
                begin
                    slot_on[sid]     = 1'b0;
                    slot_repeat[sid] = 1'b0;
                    add_result(mstt_pkg::KIND_CLEAR, int'(sid));
                end
                else
                    add_result(mstt_pkg::KIND_REJECT, int'(sid));
            end
        endcase
        expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // output side: results first, then the accepted word
    always @(posedge clk)
    begin
        mstt_pkg::res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result expected none got kind %0d slot %0d uptime %0d",
                             $time, result_kind, result_slot, uptime);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_kind", want.kind, result_kind);
                    check_field("result_slot", want.slot, result_slot);
                    check_field("uptime", want.uptime, uptime);
                    check_field("last", want.last, last);
                end
            end
            if (in_valid && in_ready)
            begin
                predict_timers(req_type, period, slot_id);
                if (word_typed)
                begin
                    void'(expected_results.pop_back());
                    expected_results.push_back(word_exp);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet == QUIET_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // receiver stalls, long hold counted here
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_word(logic [mstt_pkg::REQ_W-1:0] req,
                             logic [mstt_pkg::TICK_W-1:0] per,
                             logic [mstt_pkg::SLOT_W-1:0] sid, bit typed,
                             mstt_pkg::res_t exp);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        period     <= per;
        slot_id    <= sid;
        word_typed <= typed;
        word_exp   <= exp;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int              pick;
        mstt_pkg::req_t  req;
        logic [31:0]     per;
        mstt_pkg::res_t  exp;
        gap_pct   = 9;
        stall_pct = 60;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            exp = '{directed_rows[k].kind, directed_rows[k].slot, directed_rows[k].up, 1'b1};
            repeat (directed_rows[k].reps)
                send_word(directed_rows[k].req, directed_rows[k].per, directed_rows[k].sid,
                          directed_rows[k].typed, exp);
        end
        drain_results();

        for (int pass = 0; pass < 3; pass++)
        begin
            gap_pct   = (pass == 0) ? 9 : (pass == 1) ? 60 : 0;
            stall_pct = (pass == 0) ? 60 : (pass == 1) ? 9 : 0;
            if (pass == 2)
                hold_left = HOLD_CYCLES;
            repeat (WORDS_PER_PASS)
            begin
                pick = $urandom_range(99);
                per  = $urandom;
                if (pick < 40)
                    req = mstt_pkg::REQ_TICK;
                else if (pick < 60)
                    req = mstt_pkg::REQ_ONESHOT;
                else if (pick < 75)
                    req = mstt_pkg::REQ_PERIODIC;
                else
                    req = mstt_pkg::REQ_CLEAR;
                if (req == mstt_pkg::REQ_ONESHOT || req == mstt_pkg::REQ_PERIODIC)
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        per = $urandom_range(12, 1);
                    else if (pick < 80)
                        per = '0;
                    else if (pick < 90)
                        per = $urandom_range(200, 13);
                end
                send_word(req, per, 4'($urandom), 1'b0, '0);
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
